// ===== rtl/core/bpsd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bpsd_pkg;

    // Field and datapath widths.
    localparam int SAMPLE_BITS = 16;
    localparam int TIME_BITS   = 48;
    localparam int LEN_W       = 16;
    localparam int THR_W       = 31;
    localparam int HOLD_W      = 20;

    // A square of a two's complement sample never needs the top product bit.
    localparam int SQ_W   = 2 * SAMPLE_BITS - 1;
    // A block holds at most 2^LEN_W - 1 samples.
    localparam int SUM_W  = SQ_W + LEN_W;
    localparam int PROD_W = THR_W + LEN_W;

    // Stream packing.
    localparam int IN_DATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_W = TIME_BITS + 1;
    localparam int OUT_DATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    // Queue between the accumulating front and the decision back end.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = Q_PTR_W + 1;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LENGTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF_SAMPLES = 2'd2;

    localparam logic [LEN_W-1:0]  RST_BLOCK_LENGTH    = 16'd1024;
    localparam logic [THR_W-1:0]  RST_POWER_THRESHOLD = 31'd10737;
    localparam logic [HOLD_W-1:0] RST_HOLDOFF_SAMPLES = 20'd4800;

    // One finished block as handed from the front to the back end.
    typedef struct packed {
        logic [SUM_W-1:0]     sum;
        logic [PROD_W-1:0]    limit;
        logic [TIME_BITS-1:0] event_time;
    } t_blk;

endpackage

`default_nettype wire

// ===== rtl/core/bpsd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bpsd_front (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_accept,
    input  wire  [bpsd_pkg::SAMPLE_BITS-1:0] i_sample,
    input  wire  [bpsd_pkg::LEN_W-1:0]       i_block_length,
    input  wire  [bpsd_pkg::THR_W-1:0]       i_power_threshold,
    output logic                             o_push,
    output bpsd_pkg::t_blk                   o_blk,
    output logic                             o_pending
);

    logic [bpsd_pkg::LEN_W-1:0]     len_eff;
    logic [bpsd_pkg::LEN_W:0]       pos_inc;
    logic                           blk_end;
    logic signed [2*bpsd_pkg::SAMPLE_BITS-1:0] smp_ext;
    logic [2*bpsd_pkg::SAMPLE_BITS-1:0] sq_full;
    logic [bpsd_pkg::PROD_W-1:0]    limit;
    logic [bpsd_pkg::SUM_W-1:0]     sum_total;

    logic [bpsd_pkg::LEN_W-1:0]     r_pos, n_pos;
    logic [bpsd_pkg::TIME_BITS-1:0] r_start, n_start;
    logic [bpsd_pkg::SUM_W-1:0]     r_sum, n_sum;

    // Stage A: squared sample with its block-end mark.
    logic                           r_a_valid;
    logic [bpsd_pkg::SQ_W-1:0]      r_a_sq;
    logic                           r_a_last;
    logic [bpsd_pkg::PROD_W-1:0]    r_a_limit;
    logic [bpsd_pkg::TIME_BITS-1:0] r_a_time;

    // A zero length behaves as one sample per block.
    assign len_eff = (i_block_length == '0) ? bpsd_pkg::LEN_W'(1) : i_block_length;
    assign pos_inc = {1'b0, r_pos} + (bpsd_pkg::LEN_W + 1)'(1);
    assign blk_end = (pos_inc >= {1'b0, len_eff});
    assign smp_ext = (2*bpsd_pkg::SAMPLE_BITS)'($signed(i_sample));
    assign sq_full = smp_ext * smp_ext;
    assign limit   = bpsd_pkg::PROD_W'(i_power_threshold) * bpsd_pkg::PROD_W'(len_eff);

    // Position advances with each accepted sample; the block start at each block end.
    always_comb begin
        n_pos   = r_pos;
        n_start = r_start;
        if (i_accept) begin
            if (blk_end) begin
                n_pos   = '0;
                n_start = r_start + bpsd_pkg::TIME_BITS'(len_eff);
            end else begin
                n_pos = pos_inc[bpsd_pkg::LEN_W-1:0];
            end
        end
    end

    // Stage B: accumulate, and hand the total on at the block end.
    assign sum_total = r_sum + bpsd_pkg::SUM_W'(r_a_sq);

    always_comb begin
        n_sum = r_sum;
        if (r_a_valid) begin
            n_sum = r_a_last ? '0 : sum_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_start   <= '0;
            r_sum     <= '0;
            r_a_valid <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_start   <= n_start;
            r_sum     <= n_sum;
            r_a_valid <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_a_sq    <= sq_full[bpsd_pkg::SQ_W-1:0];
            r_a_last  <= blk_end;
            r_a_limit <= limit;
            r_a_time  <= r_start - bpsd_pkg::TIME_BITS'(len_eff);
        end
    end

    assign o_push           = r_a_valid & r_a_last;
    assign o_pending        = r_a_valid & r_a_last;
    assign o_blk.sum        = sum_total;
    assign o_blk.limit      = r_a_limit;
    assign o_blk.event_time = r_a_time;

endmodule

`default_nettype wire

// ===== rtl/core/bpsd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bpsd_queue (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_push,
    input  wire bpsd_pkg::t_blk           i_blk,
    input  wire                           i_pop,
    output bpsd_pkg::t_blk                o_head,
    output logic                          o_nonempty,
    output logic [bpsd_pkg::Q_CNT_W-1:0]  o_count
);

    bpsd_pkg::t_blk                r_mem [bpsd_pkg::Q_DEPTH];
    logic [bpsd_pkg::Q_PTR_W-1:0]  r_wr_ptr;
    logic [bpsd_pkg::Q_PTR_W-1:0]  r_rd_ptr;
    logic [bpsd_pkg::Q_CNT_W-1:0]  r_count;
    logic [bpsd_pkg::Q_CNT_W-1:0]  n_count;

    // Pointers wrap naturally at a power-of-two depth.
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + bpsd_pkg::Q_CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - bpsd_pkg::Q_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + bpsd_pkg::Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + bpsd_pkg::Q_PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_blk;
        end
    end

    assign o_head     = r_mem[r_rd_ptr];
    assign o_nonempty = (r_count != '0);
    assign o_count    = r_count;

endmodule

`default_nettype wire

// ===== rtl/core/bpsd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bpsd_back (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire bpsd_pkg::t_blk                 i_head,
    input  wire                                 i_head_valid,
    input  wire  [bpsd_pkg::HOLD_W-1:0]         i_holdoff,
    output logic                                o_pop,
    output logic                                o_tvalid,
    input  wire                                 i_tready,
    output logic [bpsd_pkg::OUT_DATA_W-1:0]     o_tdata
);

    logic                           now_over;
    logic [bpsd_pkg::TIME_BITS-1:0] diff;
    logic                           emit;
    logic                           slot_free;

    logic                           r_prev, n_prev;
    logic [bpsd_pkg::TIME_BITS-1:0] r_last_ev, n_last_ev;
    logic                           r_out_valid, n_out_valid;
    logic [bpsd_pkg::TIME_BITS-1:0] r_out_time;
    logic                           r_out_over;

    // Level decision and holdoff test; a negative distance never passes.
    assign now_over  = (i_head.sum >= bpsd_pkg::SUM_W'(i_head.limit));
    assign diff      = i_head.event_time - r_last_ev;
    assign emit      = (now_over != r_prev) && !diff[bpsd_pkg::TIME_BITS-1] &&
                       (diff > bpsd_pkg::TIME_BITS'(i_holdoff));
    assign slot_free = !r_out_valid || i_tready;

    // A block that emits nothing retires at once; an event waits for the slot.
    assign o_pop = i_head_valid && (!emit || slot_free);

    always_comb begin
        n_prev      = r_prev;
        n_last_ev   = r_last_ev;
        n_out_valid = r_out_valid && !i_tready;
        if (o_pop) begin
            n_prev = now_over;
            if (emit) begin
                n_last_ev   = i_head.event_time;
                n_out_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= 1'b0;
            r_last_ev   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_prev      <= n_prev;
            r_last_ev   <= n_last_ev;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_out_time <= i_head.event_time;
            r_out_over <= now_over;
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = {{(bpsd_pkg::OUT_DATA_W - bpsd_pkg::OUT_FIELD_W){1'b0}},
                       r_out_over, r_out_time};

endmodule

`default_nettype wire

// ===== rtl/core/block_power_silence_detector.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Silence detector on block power. Each accepted beat carries one signed
// 16-bit sample; its square is added into a block sum, and after block_length
// samples the block is over threshold when the sum is at least
// power_threshold times block_length (a zero length counts as one). When the
// level differs from the previous block and the block's event time (its start
// minus one block length, in samples, wrapping at 48 bits) lies strictly more
// than holdoff_samples after the last event, one beat goes out with that time
// and the new level. The block takes one sample every cycle: the square and
// the accumulate are pipelined in the front end, and a four-entry queue of
// finished blocks lets the event logic wait on a stalled output while samples
// keep flowing; the input stalls only when that queue is full, counting a
// block about to enter it. An event passes stage A, the queue and the output
// register. Configuration writes are accepted whenever reset is released and
// should be made while no block is in flight; an index beyond the three
// registers is ignored.
module block_power_silence_detector (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // Configuration write channel.
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire  [bpsd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [bpsd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // Sample stream.
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire  [bpsd_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // [15:0] sample
    // Event stream.
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    output logic [bpsd_pkg::OUT_DATA_W-1:0]    m_axis_tdata   // [47:0] event_time,
                                                              // [48] now_over
);

    logic [bpsd_pkg::LEN_W-1:0]   r_block_length;
    logic [bpsd_pkg::THR_W-1:0]   r_power_threshold;
    logic [bpsd_pkg::HOLD_W-1:0]  r_holdoff_samples;

    logic                         in_accept;
    logic                         push;
    logic                         pending;
    bpsd_pkg::t_blk               blk;
    bpsd_pkg::t_blk               head;
    logic                         head_valid;
    logic                         pop;
    logic [bpsd_pkg::Q_CNT_W-1:0] q_count;
    logic [bpsd_pkg::Q_CNT_W-1:0] q_claimed;

    // Configuration registers; nothing is taken while reset is held.
    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_length    <= bpsd_pkg::RST_BLOCK_LENGTH;
            r_power_threshold <= bpsd_pkg::RST_POWER_THRESHOLD;
            r_holdoff_samples <= bpsd_pkg::RST_HOLDOFF_SAMPLES;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bpsd_pkg::CFG_BLOCK_LENGTH: begin
                    r_block_length <= i_cfg_data[bpsd_pkg::LEN_W-1:0];
                end
                bpsd_pkg::CFG_POWER_THRESHOLD: begin
                    r_power_threshold <= i_cfg_data[bpsd_pkg::THR_W-1:0];
                end
                bpsd_pkg::CFG_HOLDOFF_SAMPLES: begin
                    r_holdoff_samples <= i_cfg_data[bpsd_pkg::HOLD_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Take a sample only out of reset and while the queue has room for a
    // block still in flight.
    assign q_claimed     = q_count + bpsd_pkg::Q_CNT_W'(pending);
    assign s_axis_tready = i_rst_n &&
                           (q_claimed < bpsd_pkg::Q_CNT_W'(bpsd_pkg::Q_DEPTH));
    assign in_accept     = s_axis_tvalid & s_axis_tready;

    bpsd_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (in_accept),
        .i_sample          (s_axis_tdata[bpsd_pkg::SAMPLE_BITS-1:0]),
        .i_block_length    (r_block_length),
        .i_power_threshold (r_power_threshold),
        .o_push            (push),
        .o_blk             (blk),
        .o_pending         (pending)
    );

    bpsd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_blk      (blk),
        .i_pop      (pop),
        .o_head     (head),
        .o_nonempty (head_valid),
        .o_count    (q_count)
    );

    bpsd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_valid (head_valid),
        .i_holdoff    (r_holdoff_samples),
        .o_pop        (pop),
        .o_tvalid     (m_axis_tvalid),
        .i_tready     (m_axis_tready),
        .o_tdata      (m_axis_tdata)
    );

endmodule

`default_nettype wire
